### rtl/dhd_pkg.sv
// Shared types and constants for the DNA string dictionary.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dhd_pkg;

	localparam int TABLE_SIZE  = 4096;
	localparam int ADDR_W      = $clog2(TABLE_SIZE);
	localparam int PROBE_LIMIT = 14;
	localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);
	localparam int MAX_LENGTH  = 12;
	localparam int CNT_W       = $clog2(MAX_LENGTH);
	localparam int LEN_W       = 4;
	localparam int SYM_W       = 24;
	localparam int KEY_W       = 28;
	localparam int KEY_RADIX   = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic [LEN_W-1:0] length;
		logic [SYM_W-1:0] symbols;
	} req_t;

	typedef struct packed {
		logic found;
		logic replaced;
	} rsp_t;

	typedef enum logic [1:0] {
		ALU_HORNER,
		ALU_FOLD,
		ALU_ADD
	} alu_op_t;

endpackage
`default_nettype wire

### rtl/dhd_alu.sv
// Shared arithmetic unit: base-5 key accumulation, modulo fold and slot step.
// Depends on dhd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dhd_alu (
	input  dhd_pkg::alu_op_t          op,
	input  logic [dhd_pkg::KEY_W-1:0] a,
	input  logic [dhd_pkg::KEY_W-1:0] b,
	output logic [dhd_pkg::KEY_W-1:0] y
);
	import dhd_pkg::*;

	always_comb begin
		case (op)
			ALU_HORNER: y = a * KEY_W'(KEY_RADIX) + b;
			ALU_FOLD:   y = KEY_W'(a[ADDR_W-1:0]) + (a >> ADDR_W);
			ALU_ADD:    y = a + b;
			default:    y = a;
		endcase
	end

endmodule
`default_nettype wire

### rtl/dhd_table.sv
// Key table: one write port, one registered read port.
// Depends on dhd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dhd_table (
	input  logic                       clk,
	input  logic                       we,
	input  logic [dhd_pkg::ADDR_W-1:0] waddr,
	input  logic [dhd_pkg::KEY_W-1:0]  wdata,
	input  logic [dhd_pkg::ADDR_W-1:0] raddr,
	output logic [dhd_pkg::KEY_W-1:0]  rdata
);
	import dhd_pkg::*;

	logic [KEY_W-1:0] mem [TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/double_hash_dictionary.sv
// Steps: accept the word, form the key one symbol at a time, reduce it by repeated folds,
// read and check one slot per probe, then post the result; a zero-length word skips to the result.
// One word at a time: no new word is taken until the last result is loaded into the response register.
// Reset: arst_n clears control state, then a sweep writes zero to each of the 4096 table slots;
// req_stall stays high for that sweep.
// Sequencer top level; depends on dhd_pkg, dhd_alu and dhd_table.
`timescale 1ns / 1ps
`default_nettype none
module double_hash_dictionary (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dhd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dhd_pkg::rsp_t rsp
);
	import dhd_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_KEY   = 7'b0000100,
		ST_FOLD  = 7'b0001000,
		ST_READ  = 7'b0010000,
		ST_CHECK = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic               op_q;
	logic [SYM_W-1:0]   sym_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   r_q;
	logic [ADDR_W-1:0]  step_q;
	logic [ADDR_W-1:0]  slot_q;
	logic [PROBE_W-1:0] probe_q;
	logic               found_q;
	logic               repl_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	alu_op_t            alu_op;
	logic [KEY_W-1:0]   alu_a;
	logic [KEY_W-1:0]   alu_b;
	logic [KEY_W-1:0]   alu_y;

	logic               tbl_we;
	logic [ADDR_W-1:0]  tbl_waddr;
	logic [KEY_W-1:0]   tbl_wdata;
	logic [KEY_W-1:0]   tbl_rdata;

	logic               req_take;
	logic               rsp_take;
	logic               rsp_load;
	logic [LEN_W-1:0]   len_sat;
	logic [1:0]         digit;
	logic               slot_empty;
	logic               slot_hit;
	logic               probe_last;
	logic [ADDR_W-1:0]  fold_mod;

	assign req_stall  = (state_q != ST_IDLE);
	assign req_take   = req_valid && !req_stall;
	assign rsp_take   = rsp_valid_q && !rsp_stall;
	assign rsp_load   = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign len_sat    = (req.length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : req.length;
	assign digit      = sym_q[{cnt_q, 1'b0} +: 2];
	assign slot_empty = (tbl_rdata == '0);
	assign slot_hit   = (tbl_rdata == key_q);
	assign probe_last = (probe_q == PROBE_W'(PROBE_LIMIT - 1));
	assign fold_mod   = (r_q[ADDR_W-1:0] == ADDR_W'(TABLE_SIZE - 1)) ? '0 : r_q[ADDR_W-1:0];

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			ST_KEY: begin
				alu_op = ALU_HORNER;
				alu_a  = key_q;
				alu_b  = KEY_W'({1'b0, digit} + 3'd1);
			end
			ST_FOLD: begin
				alu_op = ALU_FOLD;
				alu_a  = r_q;
			end
			ST_CHECK: begin
				alu_a  = KEY_W'(slot_q);
				alu_b  = KEY_W'(step_q);
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = slot_q;
		tbl_wdata = key_q;
		if (state_q == ST_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_q;
			tbl_wdata = '0;
		end else if (state_q == ST_CHECK && op_q == OP_INSERT && (slot_empty || probe_last)) begin
			tbl_we    = 1'b1;
		end
	end

	dhd_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	dhd_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (slot_q),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			probe_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TABLE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_take) begin
						state_q <= (req.length == '0) ? ST_DONE : ST_KEY;
					end
				end
				ST_KEY: begin
					if (cnt_q == '0) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (r_q[KEY_W-1:ADDR_W] == '0) begin
						probe_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (slot_empty || probe_last || (op_q == OP_LOOKUP && slot_hit)) begin
						state_q <= ST_DONE;
					end else begin
						probe_q <= probe_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q    <= req.opcode;
				sym_q   <= req.symbols;
				cnt_q   <= CNT_W'(len_sat - 1'b1);
				key_q   <= '0;
				found_q <= 1'b0;
				repl_q  <= 1'b0;
			end
			ST_KEY: begin
				key_q <= alu_y;
				r_q   <= alu_y;
				cnt_q <= cnt_q - 1'b1;
			end
			ST_FOLD: begin
				r_q    <= alu_y;
				step_q <= fold_mod + 1'b1;
				slot_q <= key_q[ADDR_W-1:0];
			end
			ST_CHECK: begin
				slot_q <= alu_y[ADDR_W-1:0];
				if (op_q == OP_INSERT) begin
					repl_q <= !slot_empty && probe_last;
				end else begin
					found_q <= !slot_empty && slot_hit;
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.found    <= found_q;
			rsp_q.replaced <= repl_q;
		end
	end

	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.found && rsp_q.replaced))
		else $error("found and replaced both set");

	a_first_probe_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && probe_q == '0) |-> (slot_q == key_q[ADDR_W-1:0]))
		else $error("first probe not at home slot");

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_CHECK) |-> (step_q != '0))
		else $error("probe step is zero");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (probe_q < PROBE_W'(PROBE_LIMIT)))
		else $error("probe count beyond limit");

	a_insert_no_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && op_q == OP_INSERT) |-> !found_q)
		else $error("insert reports found");

endmodule
`default_nettype wire

### bench/tb_double_hash_dictionary.sv
// Self-checking bench for the DNA string dictionary (insert and look up under double hashing).
// Predicts found/replaced from a shadow copy of the table; depends on dhd_pkg and the rtl/ files.
`timescale 1ns / 1ps
module tb_double_hash_dictionary;
	import dhd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int PROBE_PERIOD   = TABLE_SIZE * (TABLE_SIZE - 1);
	localparam int RANDOM_ITEMS   = 300;
	localparam int SHOWN_ERRORS   = 10;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [KEY_W-1:0] shadow_table [TABLE_SIZE];
	rsp_t predicted_flags [$];
	req_t inserted_strings [$];
	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int idle_pct       = 0;
	int stall_pct      = 0;

	double_hash_dictionary u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] dna_key(logic [LEN_W-1:0] len, logic [SYM_W-1:0] syms);
		logic [31:0] sum;
		logic [31:0] weight;
		int n;
		sum = 0;
		weight = 1;
		n = (len > MAX_LENGTH) ? MAX_LENGTH : len;
		for (int k = 0; k < n; k++) begin
			sum += weight * (32'(syms[2*k +: 2]) + 1);
			weight *= KEY_RADIX;
		end
		return sum[KEY_W-1:0];
	endfunction

	function automatic int probe_index(logic [KEY_W-1:0] key, int i);
		int base;
		int stride;
		base = 32'(key) % TABLE_SIZE;
		stride = 1 + 32'(key) % (TABLE_SIZE - 1);
		return (base + i * stride) % TABLE_SIZE;
	endfunction

	function automatic rsp_t dictionary_predict(req_t w);
		rsp_t r;
		logic [KEY_W-1:0] key;
		int slot;
		bit done;
		r = '0;
		slot = 0;
		done = 1'b0;
		if (w.length != 0) begin
			key = dna_key(w.length, w.symbols);
			if (w.opcode == OP_INSERT) begin
				for (int i = 0; i < PROBE_LIMIT && !done; i++) begin
					slot = probe_index(key, i);
					done = (shadow_table[slot] == 0);
				end
				shadow_table[slot] = key;
				r.replaced = !done;
			end else begin
				for (int i = 0; i < PROBE_LIMIT && !done; i++) begin
					slot = probe_index(key, i);
					if (shadow_table[slot] == 0) begin
						done = 1'b1;
					end else if (shadow_table[slot] == key) begin
						r.found = 1'b1;
						done = 1'b1;
					end
				end
			end
		end
		return r;
	endfunction

	// Rebuild a string from a key; fails on a zero digit or more than MAX_LENGTH digits.
	function automatic bit key_to_string(logic [31:0] key, output req_t w);
		logic [31:0] rest;
		int n;
		int d;
		bit ok;
		w = '0;
		rest = key;
		n = 0;
		ok = 1'b1;
		while (rest != 0 && ok) begin
			d = rest % KEY_RADIX;
			if (d == 0 || n == MAX_LENGTH) begin
				ok = 1'b0;
			end else begin
				w.symbols[2*n +: 2] = 2'(d - 1);
				n++;
				rest = rest / KEY_RADIX;
			end
		end
		w.length = LEN_W'(n);
		return ok && n > 0;
	endfunction

	function automatic req_t make_word(logic op, int len, logic [SYM_W-1:0] syms);
		req_t w;
		w.opcode = op;
		w.length = LEN_W'(len);
		w.symbols = syms;
		return w;
	endfunction

	function automatic int random_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return 0;
		if (pick < 9)
			return $urandom_range(MAX_LENGTH + 1, 15);
		return $urandom_range(1, MAX_LENGTH);
	endfunction

	function automatic void note_mismatch(string what, rsp_t exp_w, rsp_t got_w);
		mismatch_count++;
		if (mismatch_count <= SHOWN_ERRORS)
			$display("%0t: %s: expected found=%b replaced=%b, got found=%b replaced=%b",
				$realtime, what, exp_w.found, exp_w.replaced, got_w.found, got_w.replaced);
	endfunction

	// Check each accepted result word against the oldest prediction.
	always @(posedge clk) begin
		rsp_t exp_w;
		if (rsp_valid && !rsp_stall) begin
			if (predicted_flags.size() == 0) begin
				note_mismatch("unexpected word", '0, rsp);
			end else begin
				exp_w = predicted_flags.pop_front();
				if (rsp.found !== exp_w.found)
					note_mismatch("found", exp_w, rsp);
				if (rsp.replaced !== exp_w.replaced)
					note_mismatch("replaced", exp_w, rsp);
			end
		end
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(req_t w);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted_flags.push_back(dictionary_predict(w));
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (predicted_flags.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_word(make_word(OP_LOOKUP, 1, 24'h000000));
		send_word(make_word(OP_INSERT, 1, 24'h000000));
		send_word(make_word(OP_LOOKUP, 1, 24'hFFFFFC));
		send_word(make_word(OP_INSERT, 12, 24'hFFFFFF));
		send_word(make_word(OP_LOOKUP, 15, 24'hFFFFFF));
		send_word(make_word(OP_INSERT, 0, 24'hFFFFFF));
		send_word(make_word(OP_LOOKUP, 0, 24'h000000));
		send_word(make_word(OP_LOOKUP, 2, 24'h000000));
		drain_results();
	endtask

	// Fill one whole probe walk, overflow it with an alias key, then walk past it.
	task automatic test_probe_overflow();
		req_t base_w;
		req_t alias_a;
		req_t alias_b;
		req_t cand;
		logic [31:0] base_key;
		int got;
		got = 0;
		while (got < 2) begin
			base_w = make_word(OP_INSERT, MAX_LENGTH, SYM_W'($urandom));
			base_key = 32'(dna_key(base_w.length, base_w.symbols));
			got = 0;
			for (int m = 1; m < 15 && got < 2; m++) begin
				if (key_to_string(base_key + m * PROBE_PERIOD, cand)) begin
					if (got == 0)
						alias_a = cand;
					else
						alias_b = cand;
					got++;
				end
			end
		end
		alias_a.opcode = OP_INSERT;
		repeat (PROBE_LIMIT)
			send_word(base_w);
		send_word(alias_a);
		alias_a.opcode = OP_LOOKUP;
		send_word(alias_a);
		base_w.opcode = OP_LOOKUP;
		send_word(base_w);
		alias_b.opcode = OP_LOOKUP;
		send_word(alias_b);
		drain_results();
	endtask

	task automatic test_random_traffic(int n_items);
		req_t w;
		int sent;
		int pick;
		int eff_len;
		int burst;
		logic [SYM_W-1:0] junk_mask;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (inserted_strings.size() == 0 || pick < 35) begin
				w = make_word(OP_INSERT, random_length(), SYM_W'($urandom));
				if (w.length != 0)
					inserted_strings.push_back(w);
				send_word(w);
				sent++;
			end else if (pick < 65) begin
				// look up a stored string, with the bits past its length scrambled
				w = inserted_strings[$urandom_range(0, inserted_strings.size() - 1)];
				eff_len = (w.length > MAX_LENGTH) ? MAX_LENGTH : w.length;
				junk_mask = (eff_len == MAX_LENGTH) ? '0 : ~SYM_W'((1 << (2 * eff_len)) - 1);
				w.symbols ^= SYM_W'($urandom) & junk_mask;
				if (eff_len == MAX_LENGTH)
					w.length = LEN_W'($urandom_range(MAX_LENGTH, 15));
				w.opcode = OP_LOOKUP;
				send_word(w);
				sent++;
			end else if (pick < 80) begin
				send_word(make_word(OP_LOOKUP, random_length(), SYM_W'($urandom)));
				sent++;
			end else begin
				w = inserted_strings[$urandom_range(0, inserted_strings.size() - 1)];
				burst = (pick < 90) ? 1 : $urandom_range(PROBE_LIMIT - 2, PROBE_LIMIT + 2);
				repeat (burst)
					send_word(w);
				sent += burst;
			end
		end
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < TABLE_SIZE; i++)
			shadow_table[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_probe_overflow();

		idle_pct = 0;
		stall_pct = 0;
		test_random_traffic(RANDOM_ITEMS);
		idle_pct = 46;
		stall_pct = 0;
		test_random_traffic(RANDOM_ITEMS);
		idle_pct = 0;
		stall_pct = 46;
		test_random_traffic(RANDOM_ITEMS);
		idle_pct = 20;
		stall_pct = 20;
		test_random_traffic(RANDOM_ITEMS);

		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (predicted_flags.size() != 0)
			note_mismatch("missing word", predicted_flags.pop_front(), '0);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
